// File: rtl/blsp_pkg.sv
// Shared types, constants and helper functions of the bracketed list splitter.
package blsp_pkg;

  // Sizes
  localparam int POS_BITS   = 16;
  localparam int DEPTH_BITS = 8;
  localparam int SEP_SLOTS  = 4;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  // Configuration register indexes
  localparam logic [2:0] REG_OPEN_TOKEN  = 3'd0;
  localparam logic [2:0] REG_CLOSE_TOKEN = 3'd1;
  localparam logic [2:0] REG_SEP_CHARS   = 3'd2;
  localparam logic [2:0] REG_SEP_COUNT   = 3'd3;
  localparam logic [2:0] REG_EXPECTED    = 3'd4;
  localparam logic [2:0] REG_ALLOW_EMPTY = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_ITEM  = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // One input request
  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } in_t;

  // One result
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] item_start;
    logic [15:0] item_length;
    logic [15:0] error_offset;
    logic        end_of_run;
  } out_t;

  // Configuration registers
  typedef struct packed {
    logic [7:0]  open_token;
    logic [7:0]  close_token;
    logic [31:0] separator_chars;
    logic [2:0]  separator_count;
    logic [15:0] expected_items;
    logic        allow_empty;
  } cfg_t;

  // Results of one character: one or two
  typedef struct packed {
    logic [1:0] count;
    out_t       r1;
    out_t       r0;
  } rec_t;

  // Blank, tab, CR, LF
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd10);
  endfunction

  // Match against the separator slots in use
  function automatic logic is_sep(input logic [7:0] c, input logic [31:0] chars,
                                  input logic [2:0] cnt);
    logic       hit;
    logic [3:0] used;
    hit  = 1'b0;
    used = ({1'b0, cnt} > 4'(SEP_SLOTS)) ? 4'(SEP_SLOTS) : {1'b0, cnt};
    for (int i = 0; i < SEP_SLOTS; i++) begin
      if ((4'(i) < used) && (chars[8*i +: 8] == c)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// File: rtl/blsp_front.sv
// Front part: accepts characters, runs the list parser and builds result records.
module blsp_front
  import blsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic q_full,
  output logic push,
  output rec_t push_rec
);

  localparam logic [2:0] PH_LEAD      = 3'd0;
  localparam logic [2:0] PH_ITEM_LEAD = 3'd1;
  localparam logic [2:0] PH_ITEM      = 3'd2;
  localparam logic [2:0] PH_CLOSE     = 3'd3;
  localparam logic [2:0] PH_TAIL      = 3'd4;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  // Parser state
  logic [2:0]            phase, phase_next;
  logic [POS_BITS-1:0]   char_position, char_position_next;
  logic [DEPTH_BITS-1:0] nest_depth, nest_depth_next;
  logic [POS_BITS-1:0]   item_begin, item_begin_next;
  logic [POS_BITS-1:0]   last_significant, last_significant_next;
  logic [15:0]           items_seen, items_seen_next;
  logic                  failed, failed_next;
  logic [POS_BITS-1:0]   err_at, err_at_next;

  // Per-character scratch
  logic                  done, end_char;
  logic [POS_BITS-1:0]   len, end_pos;
  logic [1:0]            n;
  out_t                  res0, res1;
  logic                  c_space, c_sep, c_open, c_close;
  logic                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign c_space = is_space(in_data.char_in);
  assign c_sep   = is_sep(in_data.char_in, cfg.separator_chars, cfg.separator_count);
  assign c_open  = (cfg.open_token != 8'd0) && (in_data.char_in == cfg.open_token);
  assign c_close = (cfg.close_token != 8'd0) && (in_data.char_in == cfg.close_token);
  assign end_pos = char_position + 1'b1;

  // Parse one character, then the end of the string when it is the last one
  always_comb begin
    phase_next            = phase;
    nest_depth_next       = nest_depth;
    item_begin_next       = item_begin;
    last_significant_next = last_significant;
    items_seen_next       = items_seen;
    failed_next           = failed;
    err_at_next           = err_at;
    char_position_next    = end_pos;
    done                  = 1'b0;
    end_char              = 1'b0;
    len                   = '0;
    n                     = 2'd0;
    res0                  = '0;
    res1                  = '0;

    if (!failed_next) begin
      // Leading spaces and open token
      if (phase_next == PH_LEAD) begin
        if (c_space) begin
          done = 1'b1;
        end else if (cfg.open_token != 8'd0) begin
          if (in_data.char_in == cfg.open_token) phase_next = PH_ITEM_LEAD;
          else begin
            failed_next = 1'b1;
            err_at_next = char_position;
          end
          done = 1'b1;
        end else begin
          phase_next = PH_ITEM_LEAD;
        end
      end
      // Skip leading spaces of an item
      if (!done && phase_next == PH_ITEM_LEAD) begin
        if (c_space) begin
          done = 1'b1;
        end else begin
          item_begin_next       = char_position;
          last_significant_next = char_position;
          nest_depth_next       = '0;
          phase_next            = PH_ITEM;
        end
      end
      // Item body with nesting
      if (!done && phase_next == PH_ITEM) begin
        done = 1'b1;
        if (c_sep) begin
          if (nest_depth_next == '0) end_char = 1'b1;
        end else begin
          if (!c_space && !c_close) last_significant_next = char_position;
          if (c_open) begin
            if (nest_depth_next >= DEPTH_MAX) begin
              failed_next = 1'b1;
              err_at_next = char_position;
            end else begin
              nest_depth_next = nest_depth_next + 1'b1;
            end
          end else if (c_close) begin
            if (nest_depth_next != '0) begin
              last_significant_next = char_position;
              nest_depth_next       = nest_depth_next - 1'b1;
            end else begin
              end_char = 1'b1;
            end
          end
        end
      end
      // Item closed by a separator or close token
      if (end_char) begin
        len = (char_position == item_begin_next) ? '0
            : (last_significant_next + 1'b1 - item_begin_next);
        if (!cfg.allow_empty && len == '0) begin
          failed_next = 1'b1;
          err_at_next = item_begin_next;
        end else begin
          res0 = '{kind: KIND_ITEM, item_start: 16'(item_begin_next),
                   item_length: 16'(len), error_offset: 16'd0, end_of_run: 1'b0};
          n = 2'd1;
          if (items_seen_next != 16'hFFFF) items_seen_next = items_seen_next + 1'b1;
          if (c_close) begin
            if (cfg.expected_items != 16'd0 && items_seen_next != cfg.expected_items) begin
              failed_next = 1'b1;
              err_at_next = char_position;
            end else begin
              phase_next = PH_TAIL;
            end
          end else if (cfg.expected_items != 16'd0 &&
                       items_seen_next >= cfg.expected_items) begin
            phase_next = (cfg.close_token != 8'd0) ? PH_CLOSE : PH_TAIL;
          end else begin
            phase_next = PH_ITEM_LEAD;
          end
        end
      end
      // Close token after the full count, then trailing spaces
      if (!done && phase_next == PH_CLOSE) begin
        if (c_close) phase_next = PH_TAIL;
        else begin
          failed_next = 1'b1;
          err_at_next = char_position;
        end
      end else if (!done && phase_next == PH_TAIL) begin
        if (!c_space) begin
          failed_next = 1'b1;
          err_at_next = char_position;
        end
      end
    end

    // End of the string
    if (in_data.is_final) begin
      if (!failed_next) begin
        unique case (phase_next) inside
          PH_LEAD, PH_ITEM_LEAD: begin
            if (phase_next == PH_LEAD && cfg.open_token != 8'd0) begin
              failed_next = 1'b1;
              err_at_next = end_pos;
            end else begin
              item_begin_next = end_pos;
              if (!cfg.allow_empty) begin
                failed_next = 1'b1;
                err_at_next = end_pos;
              end else begin
                if (n == 2'd0) begin
                  res0 = '{kind: KIND_ITEM, item_start: 16'(end_pos), item_length: 16'd0,
                           error_offset: 16'd0, end_of_run: 1'b0};
                  n = 2'd1;
                end
                if (items_seen_next != 16'hFFFF) items_seen_next = items_seen_next + 1'b1;
                if ((cfg.expected_items != 16'd0 && items_seen_next != cfg.expected_items) ||
                    cfg.close_token != 8'd0) begin
                  failed_next = 1'b1;
                  err_at_next = end_pos;
                end
              end
            end
          end
          PH_ITEM: begin
            if (nest_depth_next != '0) begin
              failed_next = 1'b1;
              err_at_next = end_pos;
            end else begin
              len = last_significant_next + 1'b1 - item_begin_next;
              if (!cfg.allow_empty && len == '0) begin
                failed_next = 1'b1;
                err_at_next = item_begin_next;
              end else begin
                res0 = '{kind: KIND_ITEM, item_start: 16'(item_begin_next),
                         item_length: 16'(len), error_offset: 16'd0, end_of_run: 1'b0};
                n = 2'd1;
                if (items_seen_next != 16'hFFFF) items_seen_next = items_seen_next + 1'b1;
                if ((cfg.expected_items != 16'd0 && items_seen_next != cfg.expected_items) ||
                    cfg.close_token != 8'd0) begin
                  failed_next = 1'b1;
                  err_at_next = end_pos;
                end
              end
            end
          end
          PH_CLOSE: begin
            failed_next = 1'b1;
            err_at_next = end_pos;
          end
          default: ;
        endcase
      end

      // Status result
      if (n == 2'd0) begin
        res0 = '{kind: failed_next ? KIND_ERROR : KIND_OK, item_start: 16'd0,
                 item_length: 16'd0,
                 error_offset: failed_next ? 16'(err_at_next) : 16'd0, end_of_run: 1'b1};
      end else begin
        res1 = '{kind: failed_next ? KIND_ERROR : KIND_OK, item_start: 16'd0,
                 item_length: 16'd0,
                 error_offset: failed_next ? 16'(err_at_next) : 16'd0, end_of_run: 1'b1};
      end
      n = n + 2'd1;

      // Restart for the next string
      phase_next            = PH_LEAD;
      char_position_next    = '0;
      nest_depth_next       = '0;
      item_begin_next       = '0;
      last_significant_next = '0;
      items_seen_next       = '0;
      failed_next           = 1'b0;
      err_at_next           = '0;
    end
  end

  assign push     = accept && (n != 2'd0);
  assign push_rec = '{count: n, r1: res1, r0: res0};

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LEAD;
      char_position    <= '0;
      nest_depth       <= '0;
      item_begin       <= '0;
      last_significant <= '0;
      items_seen       <= '0;
      failed           <= 1'b0;
      err_at           <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      char_position    <= char_position_next;
      nest_depth       <= nest_depth_next;
      item_begin       <= item_begin_next;
      last_significant <= last_significant_next;
      items_seen       <= items_seen_next;
      failed           <= failed_next;
      err_at           <= err_at_next;
    end
  end

endmodule

// File: rtl/blsp_queue.sv
// Short queue of result records between the parser and the output sequencer.
module blsp_queue
  import blsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic empty,
  output rec_t head
);

  rec_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/blsp_back.sv
// Back part: sends the one or two results of each queued record in order.
module blsp_back
  import blsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  rec_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic sel;
  logic last;

  assign out_valid = !empty;
  assign out_data  = sel ? head.r1 : head.r0;
  assign last      = sel || (head.count == 2'd1);
  assign pop       = out_valid && out_ready && last;

  // Which result of the head record is shown
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (out_valid && out_ready) begin
      sel <= !last;
    end
  end

endmodule

// File: rtl/bracketed_list_splitter_top.sv
// Top level of the bracketed list splitter: configuration registers and the three parts.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_data   (char_in, is_final)
//  out      output     out_valid / out_ready  out_data  (kind, item_start, item_length,
//                                                         error_offset, end_of_run)
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// One character is parsed per cycle in the front part while the queue has room; a
// character may yield one or two results, and the back part sends one result per cycle
// while out_ready is high. A four-record queue parts the sides; in_ready drops only when
// it is full. Synchronous reset restores the register defaults and restarts the parser.
module bracketed_list_splitter_top
  import blsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;
  logic q_full, q_empty, push, pop;
  rec_t push_rec, head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_token      <= 8'd40;
      cfg.close_token     <= 8'd41;
      cfg.separator_chars <= 32'd44;
      cfg.separator_count <= 3'd1;
      cfg.expected_items  <= 16'd0;
      cfg.allow_empty     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPEN_TOKEN:  cfg.open_token      <= cfg_data[7:0];
        REG_CLOSE_TOKEN: cfg.close_token     <= cfg_data[7:0];
        REG_SEP_CHARS:   cfg.separator_chars <= cfg_data;
        REG_SEP_COUNT:   cfg.separator_count <= cfg_data[2:0];
        REG_EXPECTED:    cfg.expected_items  <= cfg_data[15:0];
        REG_ALLOW_EMPTY: cfg.allow_empty     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  blsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  blsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  blsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/bracketed_list_splitter_top_tb.sv
// Testbench of the bracketed list splitter: directed table, then random strings checked by a parser model.
module bracketed_list_splitter_top_tb;
  import blsp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int BLOCK_ITEMS  = 80;
  localparam int DEEP_OPENS   = 256;

  localparam cfg_t CFG_RESET = '{8'd40, 8'd41, 32'd44, 3'd1, 16'd0, 1'b0};
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  typedef enum logic [2:0] {
    PH_LEAD, PH_ITEM_LEAD, PH_ITEM, PH_CLOSE, PH_TAIL
  } parse_phase_e;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table; tkind/terr give the typed status where typed is set
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    logic [7:0]  ch;
    logic        fin;
    logic        typed;
    logic [1:0]  tkind;
    logic [15:0] terr;
  } dir_row_t;

  localparam int N_ROWS = 31;

  dir_row_t directed_rows [N_ROWS] = '{
    // open token missing
    '{ROW_ITEM, '0, '0, "x",   1'b1, 1'b1, KIND_ERROR, 16'd0},
    // string ends right after the open token
    '{ROW_ITEM, '0, '0, "(",   1'b1, 1'b1, KIND_ERROR, 16'd1},
    // simplest good list
    '{ROW_ITEM, '0, '0, "(",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, "a",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, ")",   1'b1, 1'b1, KIND_OK,    16'd0},
    // empty item at the close token
    '{ROW_ITEM, '0, '0, "(",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, ")",   1'b1, 1'b1, KIND_ERROR, 16'd1},
    // unbalanced nesting at the end
    '{ROW_ITEM, '0, '0, "(",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, "(",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, "a",   1'b1, 1'b1, KIND_ERROR, 16'd3},
    // leading blank, extreme characters, tab before an item, trailing blank
    '{ROW_ITEM, '0, '0, " ",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, "(",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, 8'hFF, 1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, 8'h00, 1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, ",",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, "\t",  1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, "b",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, ")",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, " ",   1'b1, 1'b1, KIND_OK,    16'd0},
    // no open token, four slots (count too large), close token and 0 as separators
    '{ROW_CFG, REG_OPEN_TOKEN,  32'd0,          '0, 1'b0, 1'b0, '0, 16'd0},
    '{ROW_CFG, REG_SEP_CHARS,   32'h0029_3B2C,  '0, 1'b0, 1'b0, '0, 16'd0},
    '{ROW_CFG, REG_SEP_COUNT,   32'd7,          '0, 1'b0, 1'b0, '0, 16'd0},
    '{ROW_CFG, REG_EXPECTED,    32'd2,          '0, 1'b0, 1'b0, '0, 16'd0},
    '{ROW_CFG, REG_ALLOW_EMPTY, 32'd1,          '0, 1'b0, 1'b0, '0, 16'd0},
    // separator equal to the close token ends the list
    '{ROW_ITEM, '0, '0, "a",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, ";",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, "b",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, ")",   1'b1, 1'b1, KIND_OK,    16'd0},
    // count reached at a separator, close token missing
    '{ROW_ITEM, '0, '0, ",",   1'b0, 1'b0, '0,         16'd0},
    '{ROW_ITEM, '0, '0, ",",   1'b1, 1'b1, KIND_ERROR, 16'd2},
    // final separator opens an empty, unreported item
    '{ROW_ITEM, '0, '0, 8'h00, 1'b1, 1'b1, KIND_ERROR, 16'd1}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Typed status that goes with the request on the input
  logic        cur_typed;
  logic [1:0]  cur_tkind;
  logic [15:0] cur_terr;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          fail_count;

  // Parser model state
  cfg_t         cfg_model;
  parse_phase_e parse_phase;
  logic [15:0]  char_pos;
  logic [15:0]  item_begin;
  logic [15:0]  last_sig;
  logic [15:0]  items_seen;
  logic [15:0]  first_error;
  logic [DEPTH_BITS-1:0] depth;
  logic         run_failed;
  int           step_count;

  out_t       pending_results[$];
  logic [7:0] str_buf[$];

  bracketed_list_splitter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- parser model

  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd10);
  endfunction

  function automatic int sep_slots_used();
    int n;
    n = cfg_model.separator_count;
    if (n > SEP_SLOTS) n = SEP_SLOTS;
    if (n > 4) n = 4;
    return n;
  endfunction

  function automatic bit is_separator(input logic [7:0] c);
    int n;
    n = sep_slots_used();
    for (int i = 0; i < n; i++) begin
      if (cfg_model.separator_chars[8*i +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // A zero token matches nothing, character 0 included
  function automatic bit is_open_tok(input logic [7:0] c);
    return (cfg_model.open_token != 8'd0) && (c == cfg_model.open_token);
  endfunction

  function automatic bit is_close_tok(input logic [7:0] c);
    return (cfg_model.close_token != 8'd0) && (c == cfg_model.close_token);
  endfunction

  function automatic void restart_parse();
    parse_phase = PH_LEAD;
    char_pos    = '0;
    depth       = '0;
    item_begin  = '0;
    last_sig    = '0;
    items_seen  = '0;
    run_failed  = 1'b0;
    first_error = '0;
  endfunction

  // Only the first error of a string is kept
  function automatic void note_error(input logic [15:0] at);
    if (!run_failed) begin
      run_failed  = 1'b1;
      first_error = at;
    end
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic [15:0] err,
                                      input logic eor);
    out_t r;
    r.kind         = kind;
    r.item_start   = start;
    r.item_length  = len;
    r.error_offset = err;
    r.end_of_run   = eor;
    pending_results.push_back(r);
    step_count++;
  endfunction

  // Empty-item rule, then count the item; true when it is accepted
  function automatic bit accept_item(input logic [15:0] len, input bit show);
    if (!cfg_model.allow_empty && len == 16'd0) begin
      note_error(item_begin);
      return 1'b0;
    end
    if (show) push_result(KIND_ITEM, item_begin, len, 16'd0, 1'b0);
    if (items_seen < 16'hFFFF) items_seen++;
    return 1'b1;
  endfunction

  // Item ended by a separator or a close token at offset r
  function automatic void close_item(input logic [7:0] c, input logic [15:0] r);
    logic [15:0] len;
    len = (r == item_begin) ? 16'd0 : 16'(last_sig + 16'd1 - item_begin);
    if (!accept_item(len, 1'b1)) return;
    if (is_close_tok(c)) begin
      if (cfg_model.expected_items != 16'd0 && items_seen != cfg_model.expected_items) begin
        note_error(r);
        return;
      end
      parse_phase = PH_TAIL;
    end else if (cfg_model.expected_items != 16'd0 && items_seen >= cfg_model.expected_items)
      begin
      parse_phase = (cfg_model.close_token != 8'd0) ? PH_CLOSE : PH_TAIL;
    end else begin
      parse_phase = PH_ITEM_LEAD;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic [15:0] pos);
    if (parse_phase == PH_LEAD) begin
      if (is_blank(c)) return;
      if (cfg_model.open_token != 8'd0) begin
        if (c == cfg_model.open_token) parse_phase = PH_ITEM_LEAD;
        else note_error(pos);
        return;
      end
      parse_phase = PH_ITEM_LEAD;
    end
    if (parse_phase == PH_ITEM_LEAD) begin
      if (is_blank(c)) return;
      item_begin  = pos;
      last_sig    = pos;
      depth       = '0;
      parse_phase = PH_ITEM;
    end
    if (parse_phase == PH_ITEM) begin
      // separator test first, so a separator that is also a token acts as a separator
      if (is_separator(c)) begin
        if (depth == '0) close_item(c, pos);
        return;
      end
      if (!is_blank(c) && !is_close_tok(c)) last_sig = pos;
      if (is_open_tok(c)) begin
        if (depth >= DEPTH_MAX) begin
          note_error(pos);
          return;
        end
        depth++;
      end else if (is_close_tok(c)) begin
        if (depth != '0) begin
          last_sig = pos;
          depth--;
        end else begin
          close_item(c, pos);
        end
      end
      return;
    end
    if (parse_phase == PH_CLOSE) begin
      if (is_close_tok(c)) parse_phase = PH_TAIL;
      else note_error(pos);
      return;
    end
    if (!is_blank(c)) note_error(pos);
  endfunction

  function automatic void check_list_end(input logic [15:0] end_pos);
    if (cfg_model.expected_items != 16'd0 && items_seen != cfg_model.expected_items)
      note_error(end_pos);
    if (cfg_model.close_token != 8'd0) note_error(end_pos);
  endfunction

  // End of the string; end_pos equals the string length
  function automatic void parse_end(input logic [15:0] end_pos);
    if (parse_phase == PH_LEAD && cfg_model.open_token != 8'd0) begin
      note_error(end_pos);
      return;
    end
    if (parse_phase == PH_LEAD || parse_phase == PH_ITEM_LEAD) begin
      // an item opened by a final separator is counted but not reported
      item_begin = end_pos;
      if (accept_item(16'd0, step_count == 0)) check_list_end(end_pos);
      return;
    end
    if (parse_phase == PH_ITEM) begin
      if (depth != '0) begin
        note_error(end_pos);
        return;
      end
      if (accept_item(16'(last_sig + 16'd1 - item_begin), 1'b1)) check_list_end(end_pos);
      return;
    end
    if (parse_phase == PH_CLOSE) note_error(end_pos);
  endfunction

  function automatic void predict_step(input in_t req);
    step_count = 0;
    if (!run_failed) parse_char(req.char_in, char_pos);
    char_pos++;
    if (req.is_final) begin
      if (!run_failed) parse_end(char_pos);
      push_result(run_failed ? KIND_ERROR : KIND_OK, 16'd0, 16'd0,
                  run_failed ? first_error : 16'd0, 1'b1);
      restart_parse();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor_blk
    out_t want;
    if (rst) begin
      cfg_model = CFG_RESET;
      restart_parse();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OPEN_TOKEN:  cfg_model.open_token      = cfg_data[7:0];
          REG_CLOSE_TOKEN: cfg_model.close_token     = cfg_data[7:0];
          REG_SEP_CHARS:   cfg_model.separator_chars = cfg_data;
          REG_SEP_COUNT:   cfg_model.separator_count = cfg_data[2:0];
          REG_EXPECTED:    cfg_model.expected_items  = cfg_data[15:0];
          REG_ALLOW_EMPTY: cfg_model.allow_empty     = cfg_data[0];
          default: ;
        endcase
      end
      // predict before checking, so the expected results are queued before any result is checked
      if (in_valid && in_ready) begin
        predict_step(in_data);
        if (cur_typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back('{cur_tkind, 16'd0, 16'd0, cur_terr, 1'b1});
        end
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none actual kind %0d start %0d",
                   $time, out_data.kind, out_data.item_start);
        end else begin
          want = pending_results.pop_front();
          check_field("kind",         want.kind,         out_data.kind);
          check_field("item_start",   want.item_start,   out_data.item_start);
          check_field("item_length",  want.item_length,  out_data.item_length);
          check_field("error_offset", want.error_offset, out_data.error_offset);
          check_field("end_of_run",   want.end_of_run,   out_data.end_of_run);
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_item(input logic [7:0] c, input logic fin, input logic typed,
                           input logic [1:0] tkind, input logic [15:0] terr);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data.char_in   = c;
    in_data.is_final  = fin;
    cur_typed         = typed;
    cur_tkind         = tkind;
    cur_terr          = terr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every expected result arrive, then let the design drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid  = 1'b0;
    cur_typed = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(REG_OPEN_TOKEN,  {24'd0, c.open_token});
    write_reg(REG_CLOSE_TOKEN, {24'd0, c.close_token});
    write_reg(REG_SEP_CHARS,   c.separator_chars);
    write_reg(REG_SEP_COUNT,   {29'd0, c.separator_count});
    write_reg(REG_EXPECTED,    {16'd0, c.expected_items});
    write_reg(REG_ALLOW_EMPTY, {31'd0, c.allow_empty});
  endtask

  task automatic send_string();
    for (int i = 0; i < str_buf.size(); i++)
      send_item(str_buf[i], i == str_buf.size() - 1, 1'b0, KIND_OK, 16'd0);
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: c.open_token = 8'd40;
      1: c.open_token = 8'd91;
      2: c.open_token = 8'd0;
      3: c.open_token = 8'd255;
      default: c.open_token = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 4))
      0: c.close_token = 8'd41;
      1: c.close_token = 8'd93;
      2: c.close_token = 8'd0;
      3: c.close_token = 8'd255;
      default: c.close_token = 8'($urandom_range(0, 255));
    endcase
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0: b = 8'd44;
        1: b = 8'd59;
        2: b = 8'd124;
        3: b = 8'd0;
        4: b = c.close_token;
        default: b = 8'($urandom_range(0, 255));
      endcase
      c.separator_chars[8*i +: 8] = b;
    end
    c.separator_count = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9)) inside
      [0:4]:   c.expected_items = 16'd0;
      9:       c.expected_items = 16'hFFFF;
      default: c.expected_items = 16'($urandom_range(1, 4));
    endcase
    c.allow_empty = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return 8'd32;
      1: return 8'd9;
      2: return 8'd13;
      default: return 8'd10;
    endcase
  endfunction

  // Mostly well-formed lists with random content; some broken, some noise
  function automatic void build_list();
    int mode;
    int n_items;
    int n_atoms;
    int slots;
    int k;
    int pos;
    bit nest_ok;
    str_buf.delete();
    mode    = $urandom_range(0, 99);
    slots   = sep_slots_used();
    nest_ok = (cfg_model.open_token != 8'd0) && (cfg_model.close_token != 8'd0);
    if (mode < 10) begin
      repeat ($urandom_range(1, 8)) str_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) str_buf.push_back(pick_blank());
    if (cfg_model.open_token != 8'd0) str_buf.push_back(cfg_model.open_token);
    if (cfg_model.expected_items >= 16'd1 && cfg_model.expected_items <= 16'd4)
      n_items = cfg_model.expected_items;
    else
      n_items = $urandom_range(1, 4);
    if (slots == 0) n_items = 1;
    for (int i = 0; i < n_items; i++) begin
      repeat ($urandom_range(0, 1)) str_buf.push_back(pick_blank());
      n_atoms = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      repeat (n_atoms) begin
        k = $urandom_range(0, 99);
        if (k < 70) begin
          str_buf.push_back(8'($urandom_range(97, 122)));
        end else if (k < 85 || !nest_ok) begin
          str_buf.push_back(pick_blank());
        end else begin
          str_buf.push_back(cfg_model.open_token);
          str_buf.push_back(8'($urandom_range(48, 57)));
          str_buf.push_back(cfg_model.close_token);
        end
      end
      repeat ($urandom_range(0, 1)) str_buf.push_back(pick_blank());
      if (i < n_items - 1)
        str_buf.push_back(cfg_model.separator_chars[8*$urandom_range(0, slots - 1) +: 8]);
    end
    if (cfg_model.close_token != 8'd0) str_buf.push_back(cfg_model.close_token);
    repeat ($urandom_range(0, 1)) str_buf.push_back(pick_blank());
    if (str_buf.size() == 0) str_buf.push_back(8'd97);
    if (mode >= 85) begin
      pos = $urandom_range(0, str_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: str_buf[pos] = 8'($urandom_range(0, 255));
        1: if (str_buf.size() > 1) repeat ($urandom_range(1, str_buf.size() - 1))
             void'(str_buf.pop_back());
        default: str_buf.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // Main sequence
  initial begin : main_blk
    cfg_t c;
    int   sent;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    out_ready      = 1'b0;
    cur_typed      = 1'b0;
    cur_tkind      = '0;
    cur_terr       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
      end else begin
        send_item(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].typed,
                  directed_rows[i].tkind, directed_rows[i].terr);
      end
    end

    // random blocks, two per idling mode
    for (int blk = 0; blk < 8; blk++) begin
      wait_idle();
      case (blk / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (blk == 0)      c = CFG_RESET;
      else if (blk == 1) c = '{8'd255, 8'd0, 32'h00FF_3B2C, 3'd7, 16'hFFFF, 1'b1};
      else if (blk == 2) c = '{8'd0, 8'd255, 32'hFFFF_FFFF, 3'd0, 16'd1, 1'b0};
      else               c = random_config();
      write_config(c);
      sent = 0;
      if (blk == 0) begin
        // nesting one level past the depth limit
        str_buf.delete();
        str_buf.push_back(8'd40);
        repeat (DEEP_OPENS) str_buf.push_back(8'd40);
        str_buf.push_back(8'd97);
        send_string();
        sent += str_buf.size();
      end
      while (sent < BLOCK_ITEMS) begin
        build_list();
        send_string();
        sent += str_buf.size();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("bracketed_list_splitter_top_tb passed");
    end else begin
      $display("bracketed_list_splitter_top_tb failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(CLK_PERIOD * 700000);
    $display("bracketed_list_splitter_top_tb failed");
    $finish;
  end

endmodule
